// File: rtl/matrix_keypad_scanner_macros.svh
// Assertion helpers for the keypad scanner.
// All of them sample on clk and stay quiet while rst_n is low.
`ifndef MATRIX_KEYPAD_SCANNER_MACROS_SVH
`define MATRIX_KEYPAD_SCANNER_MACROS_SVH

// Same-cycle implication.
`define MKS_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define MKS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/mks_pkg.sv
`default_nettype none
package mks_pkg;

  localparam int NUM_COLUMNS = 3;
  localparam int NUM_ROWS    = 4;

  localparam int COL_W = (NUM_COLUMNS > 1) ? $clog2(NUM_COLUMNS) : 1;

  localparam int ROW_LINES   = 4;   // physical row inputs
  localparam int MAP_COLUMNS = 3;   // columns covered by the key map
  localparam int TICK_W      = 8;
  localparam int CODE_W      = 7;
  localparam int DRIVE_W     = 3;

  localparam logic [TICK_W-1:0] DEFAULT_TICKS = 8'd50;
  localparam logic [TICK_W-1:0] TICK_MAX      = 8'hFF;

  localparam logic [CODE_W-1:0] CODE_ZERO = 7'h30;
  localparam logic [CODE_W-1:0] CODE_NINE = 7'h39;
  localparam logic [CODE_W-1:0] CODE_STAR = 7'h2A;
  localparam logic [CODE_W-1:0] CODE_HASH = 7'h23;

  // configuration register indexes
  typedef enum logic [0:0] {
    REG_PRESS_TICKS   = 1'b0,
    REG_RELEASE_TICKS = 1'b1
  } cfg_reg_t;

  // per-row debounce status after the current tick
  typedef struct packed {
    logic pressed;
    logic press_evt;
    logic release_evt;
    logic busy;
  } row_status_t;

  // ASCII code of key at (row, column) within the 4x3 map
  function automatic logic [CODE_W-1:0] key_code_of(input logic [1:0] row,
                                                    input logic [1:0] col);
    logic [CODE_W-1:0] code;
    code = CODE_ZERO;
    case (row)
      2'd0: code = CODE_ZERO + 7'(col) + 7'd1;
      2'd1: code = CODE_ZERO + 7'(col) + 7'd4;
      2'd2: code = (col == 2'd2) ? CODE_NINE : CODE_ZERO + 7'(col) + 7'd7;
      2'd3: begin
        case (col)
          2'd0:    code = CODE_STAR;
          2'd1:    code = CODE_ZERO;
          default: code = CODE_HASH;
        endcase
      end
      default: code = CODE_ZERO;
    endcase
    return code;
  endfunction

endpackage
`default_nettype wire

// File: rtl/mks_row_debounce.sv
`default_nettype none
module mks_row_debounce
  import mks_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              tick,
  input  wire logic              low,
  input  wire logic [TICK_W-1:0] p_need,
  input  wire logic [TICK_W-1:0] r_need,
  output row_status_t            status
);

  logic              pressed_r, pressed_nxt;
  logic [TICK_W-1:0] pcnt_r, pcnt_nxt;
  logic [TICK_W-1:0] rcnt_r, rcnt_nxt;
  logic [TICK_W-1:0] pcnt_inc, rcnt_inc;
  logic              press_evt, release_evt;

  // saturating increments
  assign pcnt_inc = (pcnt_r == TICK_MAX) ? pcnt_r : pcnt_r + 8'd1;
  assign rcnt_inc = (rcnt_r == TICK_MAX) ? rcnt_r : rcnt_r + 8'd1;

  always_comb begin
    pressed_nxt = pressed_r;
    pcnt_nxt    = pcnt_r;
    rcnt_nxt    = rcnt_r;
    press_evt   = 1'b0;
    release_evt = 1'b0;
    if (low) begin
      rcnt_nxt = '0;
      if (!pressed_r) begin
        if (pcnt_inc >= p_need) begin
          pcnt_nxt    = '0;
          pressed_nxt = 1'b1;
          press_evt   = 1'b1;
        end else begin
          pcnt_nxt = pcnt_inc;
        end
      end
    end else begin
      pcnt_nxt = '0;
      if (pressed_r) begin
        if (rcnt_inc >= r_need) begin
          rcnt_nxt    = '0;
          pressed_nxt = 1'b0;
          release_evt = 1'b1;
        end else begin
          rcnt_nxt = rcnt_inc;
        end
      end else begin
        rcnt_nxt = '0;
      end
    end
  end

  assign status.pressed     = pressed_nxt;
  assign status.press_evt   = press_evt;
  assign status.release_evt = release_evt;
  assign status.busy        = (!pressed_nxt && pcnt_nxt != '0) ||
                              (pressed_nxt && rcnt_nxt != '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pressed_r <= 1'b0;
      pcnt_r    <= '0;
      rcnt_r    <= '0;
    end else if (tick) begin
      pressed_r <= pressed_nxt;
      pcnt_r    <= pcnt_nxt;
      rcnt_r    <= rcnt_nxt;
    end
  end

endmodule
`default_nettype wire

// File: rtl/matrix_keypad_scanner.sv
`default_nettype none
// Channel | Dir | Ports                          | Payload
// in      | in  | in_tvalid/in_tready/in_tdata   | row_levels, one per 1 ms tick
// out     | out | out_tvalid/out_tready/out_tdata| column_drive, key_event, key_code
// cfg     | in  | cfg_we/cfg_addr/cfg_wdata      | press_ticks, release_ticks
//
// One tick transaction per clock while in_tready is high; each one yields exactly one result transaction.
// Per-row debounce counters, column logic and the result register all update at the
// input accept edge; the result is offered on out_* from the next cycle.
// Stalls: in_tready follows the output register (free, or being drained this cycle).
// Reset (rst_n low, synchronous): column 0, all rows released, counters zero,
// thresholds back to 50 ticks, key code zero.
`include "matrix_keypad_scanner_macros.svh"
module matrix_keypad_scanner
  import mks_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  // in_tdata: [3:0] row_levels (active low), [7:4] zero
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,
  // out_tdata: [2:0] column_drive, [3] key_event, [10:4] key_code, [15:11] zero
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [15:0]      out_tdata,
  input  wire logic        cfg_we,
  input  wire logic [0:0]  cfg_addr,
  input  wire logic [7:0]  cfg_wdata
);

  logic              in_accept;
  logic [TICK_W-1:0] press_ticks_r, release_ticks_r;
  logic [TICK_W-1:0] p_need, r_need;
  logic [COL_W-1:0]  col_r, col_nxt, col_cur;
  logic              hold_r, hold_nxt;
  logic [CODE_W-1:0] code_r, code_nxt;
  logic              busy_any, press_any;
  logic [NUM_ROWS-1:0] row_low;
  row_status_t       row_st [NUM_ROWS];
  logic              out_valid_r;
  logic [15:0]       out_data_r;
  logic [DRIVE_W-1:0] drive;

  // single output register: accept when it is empty or being taken now
  assign in_tready = !out_valid_r || out_tready;
  assign in_accept = in_tvalid && in_tready;

  // a zero threshold behaves like one
  assign p_need = (press_ticks_r == '0)   ? 8'd1 : press_ticks_r;
  assign r_need = (release_ticks_r == '0) ? 8'd1 : release_ticks_r;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      press_ticks_r   <= DEFAULT_TICKS;
      release_ticks_r <= DEFAULT_TICKS;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_addr))
        REG_PRESS_TICKS:   press_ticks_r   <= cfg_wdata;
        REG_RELEASE_TICKS: release_ticks_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // per-row debounce; rows past the physical lines never read low
  for (genvar r = 0; r < NUM_ROWS; r++) begin : g_row
    if (r < ROW_LINES) begin : g_line
      assign row_low[r] = !in_tdata[r];
    end else begin : g_none
      assign row_low[r] = 1'b0;
    end
    mks_row_debounce u_row (
      .clk    (clk),
      .rst_n  (rst_n),
      .tick   (in_accept),
      .low    (row_low[r]),
      .p_need (p_need),
      .r_need (r_need),
      .status (row_st[r])
    );
  end

  // out-of-range column index folds back to the first column
  assign col_cur = (32'(col_r) >= NUM_COLUMNS) ? '0 : col_r;

  // rows resolve in ascending order: the last row with a press or release
  // decides the shared hold, the highest row with a new press decides the code
  always_comb begin
    hold_nxt  = hold_r;
    code_nxt  = code_r;
    busy_any  = 1'b0;
    press_any = 1'b0;
    for (int r = 0; r < NUM_ROWS; r++) begin
      if (row_st[r].press_evt) begin
        hold_nxt  = 1'b1;
        press_any = 1'b1;
        if (r < ROW_LINES && 32'(col_cur) < MAP_COLUMNS)
          code_nxt = key_code_of(2'(r), 2'(col_cur));
      end
      if (row_st[r].release_evt) hold_nxt = 1'b0;
      if (row_st[r].busy) busy_any = 1'b1;
    end
  end

  // column advances only when idle: no hold and nothing mid-debounce
  always_comb begin
    col_nxt = col_cur;
    if (!hold_nxt && !busy_any) begin
      col_nxt = (col_cur == COL_W'(NUM_COLUMNS - 1)) ? '0 : col_cur + 1'b1;
    end
  end

  // one low bit selects the column; columns past the drive width are all ones
  always_comb begin
    if (32'(col_nxt) >= DRIVE_W) drive = '1;
    else                         drive = ~(3'b001 << col_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      hold_r <= 1'b0;
      code_r <= '0;
    end else if (in_accept) begin
      col_r  <= col_nxt;
      hold_r <= hold_nxt;
      code_r <= code_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_accept) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) out_data_r <= {5'd0, code_nxt, press_any, drive};
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // checks
  `MKS_ASSERT_NEXT(a_result_follows, in_accept, out_tvalid, "tick without result")
  `MKS_ASSERT_NEXT(a_press_holds, in_accept && hold_nxt, hold_r, "hold not registered")
  `MKS_ASSERT_NEXT(a_col_idle, !in_accept, $stable(col_r), "column moved without tick")
  `MKS_ASSERT_IMPL(a_drive_one_low, out_tvalid && (out_tdata[3] == 1'b1),
                   $onehot(~out_tdata[2:0]), "event without a single driven column")

endmodule
`default_nettype wire
